// ===== sv/mexp_pkg.sv =====
// Shared constants for the modular exponentiation unit.
package mexp_pkg;

  localparam int MOD_WIDTH_DEF = 14;
  localparam int EXP_WIDTH_DEF = 7;

endpackage

// ===== sv/modular_exponentiation_unit.sv =====
// Modular exponentiation: power_result = base_value ** exponent mod modulus.
//
//   channel   signals                        direction   word
//   in        in_valid, in_stall             sink        base_value, exponent
//   out       out_valid, out_stall           source      power_result
//   cfg       cfg_write_en, cfg_write_data   sink        modulus
//
// One word at a time. The shared bit-serial multiplier serves every product; a word
// needs one base reduction, one squaring per significant exponent bit and one
// multiply per set exponent bit. Modulus 0 or 1 skips the multiplier and gives
// result 0 once the output register is free.
// Reset (rst, synchronous) sets modulus to 1 and empties the output register.
// in_stall is high while a word is in work; a result waiting on out_stall does not
// block the next word, which then holds only at its own result.
module modular_exponentiation_unit #(
  parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MOD_WIDTH-1:0] base_value,
  input  logic [EXP_WIDTH-1:0] exponent,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [MOD_WIDTH-1:0] power_result,
  input  logic                 cfg_write_en,
  input  logic [MOD_WIDTH-1:0] cfg_write_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_NEXT = 6'b000100,
    S_MUL  = 6'b001000,
    S_SQR  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t               state;
  logic [MOD_WIDTH-1:0] mod_r;
  logic [MOD_WIDTH-1:0] base_r;
  logic [MOD_WIDTH-1:0] acc_r;
  logic [EXP_WIDTH-1:0] exp_r;

  logic                 in_take;
  logic                 out_free;
  logic                 mod_big;
  logic                 mul_start;
  logic                 mul_done;
  logic [MOD_WIDTH-1:0] mul_a;
  logic [MOD_WIDTH-1:0] mul_b;
  logic [MOD_WIDTH-1:0] mul_prod;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign mod_big  = (mod_r > MOD_WIDTH'(1));

  // operand select: base reduction is 1 * base mod m
  always_comb begin
    mul_a = base_r;
    mul_b = base_r;
    case (state)
      S_IDLE: begin
        mul_a = MOD_WIDTH'(1);
        mul_b = base_value;
      end
      S_NEXT: begin
        if (exp_r[0]) begin
          mul_a = acc_r;
        end
      end
      default: begin
        mul_a = base_r;
        mul_b = base_r;
      end
    endcase
  end

  assign mul_start = (in_take && mod_big)
                  || (state == S_NEXT && exp_r != '0)
                  || (state == S_MUL && mul_done);

  mexp_mulmod #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .m       (mod_r),
    .product (mul_prod),
    .done    (mul_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_r <= MOD_WIDTH'(1);
    end else if (cfg_write_en) begin
      mod_r <= cfg_write_data;
    end
  end

  // load on a finished word, drop once the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            exp_r <= exponent;
            if (mod_big) begin
              state <= S_RED;
            end else begin
              acc_r <= '0;
              state <= S_OUT;
            end
          end
        end
        S_RED: begin
          if (mul_done) begin
            base_r <= mul_prod;
            acc_r  <= MOD_WIDTH'(1);
            state  <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (exp_r == '0) begin
            state <= S_OUT;
          end else if (exp_r[0]) begin
            state <= S_MUL;
          end else begin
            state <= S_SQR;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            acc_r <= mul_prod;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          if (mul_done) begin
            base_r <= mul_prod;
            exp_r  <= exp_r >> 1;
            state  <= S_NEXT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            power_result <= acc_r;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state != S_IDLE)
    else $error("accepted word did not start work");

  a_done_in_work: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_RED || state == S_MUL || state == S_SQR))
    else $error("multiplier finished outside a multiply state");

  a_out_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && !out_valid |=> out_valid)
    else $error("finished result not presented");

endmodule

// ===== sv/mexp_mulmod.sv =====
// Bit-serial modular multiplier: product = a * b mod m, a double and add per b bit.
module mexp_mulmod #(
  parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MOD_WIDTH-1:0] a,
  input  logic [MOD_WIDTH-1:0] b,
  input  logic [MOD_WIDTH-1:0] m,
  output logic [MOD_WIDTH-1:0] product,
  output logic                 done
);

  localparam int CW = $clog2(MOD_WIDTH + 1);

  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] addend;
  logic [MOD_WIDTH-1:0] bsh;
  logic [MOD_WIDTH-1:0] m_r;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic                 phase;

  logic [MOD_WIDTH:0] dbl;
  logic [MOD_WIDTH:0] dbl_red;
  logic [MOD_WIDTH:0] sum;
  logic [MOD_WIDTH:0] sum_red;

  // acc < m and addend < m keep both sums below 2m: one subtract reduces
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum     = {1'b0, acc} + {1'b0, addend};
    sum_red = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        phase  <= 1'b0;
        cnt    <= CW'(MOD_WIDTH);
        acc    <= '0;
        addend <= a;
        bsh    <= b;
        m_r    <= m;
      end else if (busy) begin
        if (!phase) begin
          acc   <= dbl_red[MOD_WIDTH-1:0];
          phase <= 1'b1;
        end else begin
          if (bsh[MOD_WIDTH-1]) begin
            acc <= sum_red[MOD_WIDTH-1:0];
          end
          bsh   <= bsh << 1;
          cnt   <= cnt - CW'(1);
          phase <= 1'b0;
          if (cnt == CW'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign product = acc;

endmodule
